@@ sv/pwmcap_pkg.sv @@
// Shared codes for the PWM input capture measurement block.
// Holds phase codes, the duty scale and the back-end state type.
// No dependencies.
package pwmcap_pkg;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_FALL = 2'd1;
    localparam logic [1:0] PHASE_RISE = 2'd2;

    localparam int        DUTY_WIDTH = 7;
    localparam logic [6:0] DUTY_SCALE = 7'd100;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } back_state_t;

endpackage

@@ sv/pwmcap_front.sv @@
// Front end: accepts capture words, tracks phase and stored times.
// Pushes one job per edge into the queue. Depends on pwmcap_pkg.
module pwmcap_front
    import pwmcap_pkg::*;
#(
    parameter int COUNT_WIDTH = 16,
    parameter int JOB_WIDTH   = 3 * COUNT_WIDTH + 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COUNT_WIDTH-1:0] captured_ticks,
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic [JOB_WIDTH-1:0]   push_data
);

    logic [1:0]             phase_reg, phase_next;
    logic                   measured_reg, measured_next;
    logic [COUNT_WIDTH-1:0] high_reg, high_next;
    logic [COUNT_WIDTH-1:0] low_reg, low_next;
    logic [COUNT_WIDTH-1:0] period_reg, period_next;
    logic                   take;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign take       = in_valid & push_ready;

    always_comb
    begin
        phase_next    = PHASE_FALL;
        measured_next = measured_reg;
        high_next     = high_reg;
        low_next      = low_reg;
        period_next   = period_reg;
        case (phase_reg)
            PHASE_FALL:
            begin
                high_next  = captured_ticks;
                phase_next = PHASE_RISE;
            end
            PHASE_RISE:
            begin
                low_next      = captured_ticks;
                period_next   = COUNT_WIDTH'(high_reg + captured_ticks);
                measured_next = 1'b1;
                phase_next    = PHASE_FALL;
            end
            default:
            begin
                phase_next = PHASE_FALL;
            end
        endcase
    end

    assign push_data = {phase_next, measured_next, high_next, low_next, period_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_IDLE;
            measured_reg <= 1'b0;
            high_reg     <= '0;
            low_reg      <= '0;
            period_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            measured_reg <= measured_next;
            high_reg     <= high_next;
            low_reg      <= low_next;
            period_reg   <= period_next;
        end
    end

endmodule

@@ sv/pwmcap_fifo.sv @@
// Two-entry job queue between front and back ends.
// Register based, one write and one read per cycle. No dependencies.
module pwmcap_fifo #(
    parameter int WIDTH = 51
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push & !do_pop)
            count_next = count_reg + 2'd1;
        else if (!do_push & do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

endmodule

@@ sv/pwmcap_back.sv @@
// Back end: takes a job, forms on-time times 100, divides by the period
// one quotient bit per cycle, saturates, holds the result word. Uses pwmcap_pkg.
module pwmcap_back
    import pwmcap_pkg::*;
#(
    parameter int COUNT_WIDTH = 16,
    parameter int JOB_WIDTH   = 3 * COUNT_WIDTH + 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  logic [JOB_WIDTH-1:0]   pop_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COUNT_WIDTH-1:0] on_time,
    output logic [COUNT_WIDTH-1:0] off_time,
    output logic [COUNT_WIDTH-1:0] period_ticks,
    output logic [DUTY_WIDTH-1:0]  duty_percent,
    output logic [1:0]             edge_phase,
    output logic                   period_valid
);

    localparam int QW    = COUNT_WIDTH + DUTY_WIDTH;
    localparam int CNT_W = $clog2(QW);

    back_state_t            state_reg, state_next;
    logic [1:0]             phase_reg;
    logic                   measured_reg;
    logic [COUNT_WIDTH-1:0] on_reg, off_reg, per_reg;
    logic [QW-1:0]          div_reg;
    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [COUNT_WIDTH:0]   rem_shift;
    logic                   fits;
    logic                   out_free;
    logic [DUTY_WIDTH-1:0]  duty_sat;

    assign pop_ready = (state_reg == ST_IDLE);
    assign rem_shift = {rem_reg, div_reg[QW-1]};
    assign fits      = (rem_shift >= {1'b0, per_reg});
    assign out_free  = !out_valid | out_ready;
    assign duty_sat  = (div_reg > QW'(DUTY_SCALE)) ? DUTY_SCALE : div_reg[DUTY_WIDTH-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (pop_valid) state_next = ST_MUL;
            ST_MUL:  state_next = (per_reg == '0) ? ST_OUT : ST_DIV;
            ST_DIV:  if (cnt_reg == '0) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                    {phase_reg, measured_reg, on_reg, off_reg, per_reg} <= pop_data;
            end
            ST_MUL:
            begin
                div_reg <= (per_reg == '0) ? '0 : QW'(on_reg) * QW'(DUTY_SCALE);
                rem_reg <= '0;
                cnt_reg <= CNT_W'(QW - 1);
            end
            ST_DIV:
            begin
                rem_reg <= fits ? COUNT_WIDTH'(rem_shift - {1'b0, per_reg})
                                : rem_shift[COUNT_WIDTH-1:0];
                div_reg <= {div_reg[QW-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            on_time      <= on_reg;
            off_time     <= off_reg;
            period_ticks <= per_reg;
            duty_percent <= duty_sat;
            edge_phase   <= phase_reg;
            period_valid <= measured_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (state_reg == ST_OUT && out_free)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

endmodule

@@ sv/pwm_input_capture_measure_top.sv @@
// PWM input capture measurement, top level.
// Instantiates pwmcap_front, pwmcap_fifo and pwmcap_back; uses pwmcap_pkg.
//
// Input channel (in_valid/in_ready, captured_ticks): one word per capture
// edge, holding the ticks since the previous edge. The first edge after
// reset arms; falling edges record on-time, rising edges off-time and period.
// Output channel (out_valid/out_ready): one result word per edge with the
// stored times, duty percent (0..100), phase after the edge and a valid mark.
// The serial divider forms one quotient bit per cycle over a COUNT_WIDTH + 7
// bit quotient and takes no new word until its result is in the output
// register. A two-entry queue parts the front end from the divider, so up
// to three further words are accepted while a result waits: one held by
// the divider and two in the queue.
// Reset clears phase, stored times and all handshake state; no word is
// pending afterward. When the receiver stalls, the result holds, the
// divider finishes its job and waits, and in_ready drops once the queue fills.
module pwm_input_capture_measure_top
    import pwmcap_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COUNT_WIDTH-1:0] captured_ticks,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COUNT_WIDTH-1:0] on_time,
    output logic [COUNT_WIDTH-1:0] off_time,
    output logic [COUNT_WIDTH-1:0] period_ticks,
    output logic [DUTY_WIDTH-1:0]  duty_percent,
    output logic [1:0]             edge_phase,
    output logic                   period_valid
);

    localparam int JW = 3 * COUNT_WIDTH + 3;

    logic          push_valid, push_ready;
    logic [JW-1:0] push_data;
    logic          pop_valid, pop_ready;
    logic [JW-1:0] pop_data;

    pwmcap_front #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .JOB_WIDTH   (JW)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .captured_ticks (captured_ticks),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    pwmcap_fifo #(
        .WIDTH (JW)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pwmcap_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .JOB_WIDTH   (JW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .on_time      (on_time),
        .off_time     (off_time),
        .period_ticks (period_ticks),
        .duty_percent (duty_percent),
        .edge_phase   (edge_phase),
        .period_valid (period_valid)
    );

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duty_percent <= DUTY_SCALE)
        else $error("duty above full scale");

    a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && period_ticks == '0 |-> duty_percent == '0)
        else $error("nonzero duty with zero period");

    a_not_measured: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !period_valid |-> period_ticks == '0 && off_time == '0)
        else $error("period reported before first full measurement");

    a_phase_armed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> edge_phase == PHASE_FALL || edge_phase == PHASE_RISE)
        else $error("result carries idle phase");

endmodule
